// File: rtl/cbs_pkg.sv
// ----------------------------------------------------------------------------
// Chained byte scrambler package
// Request type, direction encoding, key table, bit permutations and the
// modulo-7 and modulo-13 residue functions used by the scrambler core.
// ----------------------------------------------------------------------------
package cbs_pkg;

   localparam int unsigned PermCount  = 7;
   localparam int unsigned KeyEntries = 13;

   typedef struct packed {
      logic       func;
      logic [7:0] link_byte;
      logic [7:0] data_in;
   } req_type;

   typedef enum logic {
      FUNC_OBFUSCATE   = 1'b0,
      FUNC_DEOBFUSCATE = 1'b1
   } func_type;

   // Output bit d of permutation k is taken from input bit PERM_SRC[k][d].
   localparam logic [2:0] PERM_SRC [0:PermCount-1][0:7] = '{
      '{3'd0, 3'd2, 3'd4, 3'd6, 3'd1, 3'd3, 3'd5, 3'd7},
      '{3'd1, 3'd7, 3'd2, 3'd0, 3'd5, 3'd4, 3'd3, 3'd6},
      '{3'd2, 3'd3, 3'd6, 3'd4, 3'd7, 3'd1, 3'd0, 3'd5},
      '{3'd4, 3'd0, 3'd5, 3'd1, 3'd3, 3'd6, 3'd7, 3'd2},
      '{3'd3, 3'd5, 3'd1, 3'd7, 3'd6, 3'd2, 3'd4, 3'd0},
      '{3'd5, 3'd6, 3'd7, 3'd3, 3'd2, 3'd0, 3'd1, 3'd4},
      '{3'd6, 3'd1, 3'd0, 3'd5, 3'd4, 3'd7, 3'd2, 3'd3}
   };

   // Since 8 is 1 modulo 7, the octal digits can simply be summed twice.
   function automatic logic [2:0] mod7(input logic [7:0] p);
      logic [4:0] s1;
      logic [3:0] s2;
      s1 = 5'(p[7:6]) + 5'(p[5:3]) + 5'(p[2:0]);
      s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
      if (s2 >= 4'd7) begin
         s2 = s2 - 4'd7;
      end
      return s2[2:0];
   endfunction

   // Since 16 is 3 modulo 13, fold the high nibble and then reduce by
   // conditional subtraction.
   function automatic logic [3:0] mod13(input logic [7:0] p);
      logic [5:0] v;
      v = 6'(p[7:4]) * 6'd3 + 6'(p[3:0]);
      if (v >= 6'd52) begin
         v = v - 6'd52;
      end
      if (v >= 6'd26) begin
         v = v - 6'd26;
      end
      if (v >= 6'd13) begin
         v = v - 6'd13;
      end
      return v[3:0];
   endfunction

   function automatic logic [7:0] key_byte(input logic [3:0] t);
      logic [7:0] k;
      unique case (t)
         4'd0:    k = 8'h26;
         4'd1:    k = 8'hFF;
         4'd2:    k = 8'hE8;
         4'd3:    k = 8'hEF;
         4'd4:    k = 8'h42;
         4'd5:    k = 8'hD6;
         4'd6:    k = 8'h01;
         4'd7:    k = 8'h54;
         4'd8:    k = 8'h14;
         4'd9:    k = 8'hA3;
         4'd10:   k = 8'h80;
         4'd11:   k = 8'hFD;
         4'd12:   k = 8'h6E;
         default: k = 8'h00;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] perm_fwd(input logic [2:0] k, input logic [7:0] v);
      logic [7:0] r;
      r = '0;
      for (int d = 0; d < 8; d++) begin
         r[d] = v[PERM_SRC[k][d]];
      end
      return r;
   endfunction

   function automatic logic [7:0] perm_inv(input logic [2:0] k, input logic [7:0] v);
      logic [7:0] r;
      r = '0;
      for (int d = 0; d < 8; d++) begin
         r[PERM_SRC[k][d]] = v[d];
      end
      return r;
   endfunction

endpackage

// File: rtl/chained_byte_scrambler.sv
// ----------------------------------------------------------------------------
// Chained byte scrambler
// Two-register pipeline around the core, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Each request carries a direction, the previous byte of the stream and a
// data byte, and produces exactly one result byte. A request is registered
// on acceptance, scrambled by the core and registered again, so its result
// is presented from the result register and is held there until taken.
// Both registers advance whenever the one ahead of them is empty or being
// taken, so a new request can be accepted every cycle while results are
// taken; while a result is stalled one further request is still accepted
// into the first register, after which the input stalls too. The block
// holds no state between requests and reset only empties the pipeline.
module chained_byte_scrambler (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic [7:0] req_link_byte,
   input  logic [7:0] req_data_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_out
);

   logic             s1_valid_ff;
   logic             s1_valid_in;
   cbs_pkg::req_type s1_req_ff;
   logic             s1_load;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [7:0]       rsp_data_ff;
   logic [7:0]       core_data;
   logic             s2_load;

   assign s2_load   = !rsp_valid_ff || !rsp_stall;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign req_stall = !s1_load;

   assign s1_valid_in  = s1_load ? req_valid : s1_valid_ff;
   assign rsp_valid_in = s2_load ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && req_valid) begin
         s1_req_ff.func      <= req_func;
         s1_req_ff.link_byte <= req_link_byte;
         s1_req_ff.data_in   <= req_data_in;
      end
      if (s2_load && s1_valid_ff) begin
         rsp_data_ff <= core_data;
      end
   end

   cbs_core u_core (
      .req      (s1_req_ff),
      .data_out (core_data)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;

   // Input back-pressure only when both pipeline registers are occupied.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled with an empty pipeline register");

   // A registered request moves into the result register when it is free.
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_load) |=> rsp_valid_ff)
      else $error("registered request lost on its way to the result register");

   // An accepted request is always held in the first register next cycle.
   a_capture: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted request not captured");

endmodule

// File: rtl/cbs_core.sv
// ----------------------------------------------------------------------------
// Chained byte scrambler core
// Combinational scramble of one registered request: key lookup, XOR and
// bit permutation in either direction.
// ----------------------------------------------------------------------------
module cbs_core (
   input  cbs_pkg::req_type req,
   output logic [7:0]       data_out
);

   logic [2:0] perm_sel;
   logic [3:0] key_sel;
   logic [7:0] key;

   always_comb begin
      perm_sel = cbs_pkg::mod7(req.link_byte);
      key_sel  = cbs_pkg::mod13(req.link_byte);
      key      = cbs_pkg::key_byte(key_sel);
      unique case (cbs_pkg::func_type'(req.func))
         cbs_pkg::FUNC_OBFUSCATE: begin
            data_out = cbs_pkg::perm_fwd(perm_sel, req.data_in ^ req.link_byte ^ key);
         end
         cbs_pkg::FUNC_DEOBFUSCATE: begin
            data_out = cbs_pkg::perm_inv(perm_sel, req.data_in) ^ key ^ req.link_byte;
         end
         default: begin
            data_out = '0;
         end
      endcase
   end

endmodule
